/* src/cah_pkg.sv */
// Shared types, constants and helpers for the caller address histogram.
`default_nettype none

package cah_pkg;

  localparam int unsigned SLOT_COUNT    = 16;
  localparam int unsigned KNOWN_CALLERS = 5;
  localparam int unsigned OFFSET_DEPTH  = 8;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BIN_W   = 4;

  localparam int unsigned SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned KNOWN_IDX_W = $clog2(KNOWN_CALLERS + 1);
  localparam int unsigned RES_IDX_W   =
      (SLOT_IDX_W > KNOWN_IDX_W) ? SLOT_IDX_W : KNOWN_IDX_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [ADDR_W-1:0] CALLER_OFFSETS [OFFSET_DEPTH] = '{
    64'h0000_0000_0379_4c78,
    64'h0000_0000_0384_6518,
    64'h0000_0000_0384_69d0,
    64'h0000_0000_03a5_ce2c,
    64'h0000_0000_03a5_d7f4,
    64'h0,
    64'h0,
    64'h0
  };

  typedef enum logic [1:0] {
    KIND_KNOWN = 2'd0,
    KIND_EXIST = 2'd1,
    KIND_NEW   = 2'd2,
    KIND_FULL  = 2'd3
  } hit_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } cah_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } cah_sts_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* src/cah_ctrl.sv */
// Sequencer for the caller address histogram: load, compare, update.
`default_nettype none

module cah_ctrl import cah_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire cah_sts_t sts_i,
  output cah_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!sts_i.out_blocked) begin
          state_d = in_valid_i ? ST_CMP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
      end
      ST_UPD: begin
        // new word may enter as the result moves to the output register
        in_stall_o = sts_i.out_blocked;
        cmd_o.upd  = !sts_i.out_blocked;
        cmd_o.load = !sts_i.out_blocked && in_valid_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/cah_dp.sv */
// Datapath: known-caller and slot compare, counter tables, output register.
`default_nettype none

module cah_dp import cah_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ADDR_W-1:0]  cfg_wdata_i,
  input  wire logic [ADDR_W-1:0]  return_address_i,
  input  wire cah_cmd_t           cmd_i,
  output cah_sts_t                sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              hit_kind_o,
  output logic [BIN_W-1:0]        bin_index_o,
  output logic [COUNT_W-1:0]      bin_count_o,
  output logic [COUNT_W-1:0]      other_count_o
);

  logic                  base_nz_q;
  logic [ADDR_W-1:0]     known_addr_q [KNOWN_CALLERS];
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     slot_addr_q  [SLOT_COUNT];
  logic [COUNT_W-1:0]    slot_cnt_q   [SLOT_COUNT];
  logic [COUNT_W-1:0]    known_cnt_q  [KNOWN_CALLERS+1];

  hit_kind_e             res_kind_q, res_kind_d;
  logic [RES_IDX_W-1:0]  res_idx_q, res_idx_d;

  logic                  out_valid_q;
  hit_kind_e             out_kind_q;
  logic [BIN_W-1:0]      out_idx_q;
  logic [COUNT_W-1:0]    out_cnt_q, out_other_q;

  logic                  known_hit;
  logic [KNOWN_IDX_W-1:0] known_idx;
  logic                  slot_found, slot_eq;
  logic [SLOT_IDX_W-1:0] slot_idx;

  logic [KNOWN_IDX_W-1:0] k_sel;
  logic [SLOT_IDX_W-1:0]  s_sel;
  logic [COUNT_W-1:0]     known_inc, slot_inc, other_inc;
  logic [RES_IDX_W+BIN_W-1:0] idx_ext;

  // configuration: precompute the absolute caller addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_nz_q <= 1'b0;
    end else if (cfg_we_i) begin
      base_nz_q <= |cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      for (int i = 0; i < KNOWN_CALLERS; i++) begin
        known_addr_q[i] <= cfg_wdata_i + CALLER_OFFSETS[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) addr_q <= return_address_i;
  end

  // compare
  always_comb begin
    known_hit = 1'b0;
    known_idx = '0;
    for (int i = KNOWN_CALLERS - 1; i >= 0; i--) begin
      if (base_nz_q && addr_q == known_addr_q[i]) begin
        known_hit = 1'b1;
        known_idx = KNOWN_IDX_W'(i);
      end
    end
  end

  always_comb begin
    slot_found = 1'b0;
    slot_eq    = 1'b0;
    slot_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_addr_q[i] == addr_q || slot_addr_q[i] == '0) begin
        slot_found = 1'b1;
        slot_eq    = (slot_addr_q[i] == addr_q);
        slot_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (known_hit) begin
      res_kind_d = KIND_KNOWN;
      res_idx_d  = RES_IDX_W'(known_idx);
    end else if (slot_found) begin
      res_kind_d = slot_eq ? KIND_EXIST : KIND_NEW;
      res_idx_d  = RES_IDX_W'(slot_idx);
    end else begin
      res_kind_d = KIND_FULL;
      res_idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      res_kind_q <= res_kind_d;
      res_idx_q  <= res_idx_d;
    end
  end

  // update
  assign k_sel     = res_idx_q[KNOWN_IDX_W-1:0];
  assign s_sel     = res_idx_q[SLOT_IDX_W-1:0];
  assign known_inc = sat_inc(known_cnt_q[k_sel]);
  assign slot_inc  = sat_inc(slot_cnt_q[s_sel]);
  assign other_inc = sat_inc(known_cnt_q[KNOWN_CALLERS]);
  assign idx_ext   = {{BIN_W{1'b0}}, res_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= KNOWN_CALLERS; i++) known_cnt_q[i] <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_addr_q[i] <= '0;
        slot_cnt_q[i]  <= '0;
      end
    end else if (cmd_i.upd) begin
      case (res_kind_q)
        KIND_KNOWN: known_cnt_q[k_sel] <= known_inc;
        KIND_EXIST: begin
          known_cnt_q[KNOWN_CALLERS] <= other_inc;
          slot_cnt_q[s_sel]          <= slot_inc;
        end
        KIND_NEW: begin
          known_cnt_q[KNOWN_CALLERS] <= other_inc;
          slot_addr_q[s_sel]         <= addr_q;
          slot_cnt_q[s_sel]          <= COUNT_W'(1);
        end
        default: known_cnt_q[KNOWN_CALLERS] <= other_inc;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.upd) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_kind_q <= res_kind_q;
      case (res_kind_q)
        KIND_KNOWN: begin
          out_idx_q   <= idx_ext[BIN_W-1:0];
          out_cnt_q   <= known_inc;
          out_other_q <= known_cnt_q[KNOWN_CALLERS];
        end
        KIND_EXIST: begin
          out_idx_q   <= idx_ext[BIN_W-1:0];
          out_cnt_q   <= slot_inc;
          out_other_q <= other_inc;
        end
        KIND_NEW: begin
          out_idx_q   <= idx_ext[BIN_W-1:0];
          out_cnt_q   <= COUNT_W'(1);
          out_other_q <= other_inc;
        end
        default: begin
          out_idx_q   <= '0;
          out_cnt_q   <= '0;
          out_other_q <= other_inc;
        end
      endcase
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign hit_kind_o    = 2'(out_kind_q);
  assign bin_index_o   = out_idx_q;
  assign bin_count_o   = out_cnt_q;
  assign other_count_o = out_other_q;

endmodule

`default_nettype wire

/* src/caller_address_histogram_top.sv */
// Top level of the caller address histogram.
`default_nettype none

// Counts call events by return address. If the configured module base is
// nonzero, an address equal to it plus one of five caller offsets bumps that
// caller's counter; any other address bumps the unknown-caller counter and is
// binned into a 16-entry content-addressed slot table (first matching or empty
// slot wins, a full table drops the address). All counters saturate at 32
// bits. Each word is compared against all slots and the caller addresses in
// parallel, then the selected counter is updated. The next word is taken
// during the update cycle as long as the output register is free. The counters
// and the slot table reset at once; no clearing pass. Write module_base only while
// the block is idle.
module caller_address_histogram_top import cah_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [ADDR_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ADDR_W-1:0]  return_address_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              hit_kind_o,
  output logic [BIN_W-1:0]        bin_index_o,
  output logic [COUNT_W-1:0]      bin_count_o,
  output logic [COUNT_W-1:0]      other_count_o
);

  cah_cmd_t cmd;
  cah_sts_t sts;

  cah_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cah_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .return_address_i (return_address_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_kind_o       (hit_kind_o),
    .bin_index_o      (bin_index_o),
    .bin_count_o      (bin_count_o),
    .other_count_o    (other_count_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for caller_address_histogram_top: random and directed calls checked against a bin model.
module tb;
  import cah_pkg::*;

  typedef struct packed {
    hit_kind_e            kind;
    logic [BIN_W-1:0]     index;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   other;
  } bin_update_t;

  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
  localparam int unsigned       POOL_SIZE = 20;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata_i      = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic [ADDR_W-1:0]  return_address_i = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [1:0]         hit_kind_o;
  logic [BIN_W-1:0]   bin_index_o;
  logic [COUNT_W-1:0] bin_count_o;
  logic [COUNT_W-1:0] other_count_o;

  caller_address_histogram_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .return_address_i (return_address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_kind_o       (hit_kind_o),
    .bin_index_o      (bin_index_o),
    .bin_count_o      (bin_count_o),
    .other_count_o    (other_count_o)
  );

  always #1 clk_i = ~clk_i;

  // bin model state
  logic [ADDR_W-1:0]  base_model;
  logic [COUNT_W-1:0] caller_tally [KNOWN_CALLERS];
  logic [COUNT_W-1:0] other_tally;
  logic [ADDR_W-1:0]  slot_addr [SLOT_COUNT];
  logic [COUNT_W-1:0] slot_tally [SLOT_COUNT];

  logic [ADDR_W-1:0]  addresses_to_send [$];
  bin_update_t        bin_updates_due [$];
  logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];

  bit          word_taken;
  bit          result_taken;
  bit          lazy = 1'b1;
  int          send_gap;
  int          stall_left;
  int          hold_left;
  int          next_hold = 500;
  int          results_seen;
  int          mismatches;

  initial begin
    base_model  = '0;
    other_tally = '0;
    for (int i = 0; i < KNOWN_CALLERS; i++) caller_tally[i] = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_addr[i]  = '0;
      slot_tally[i] = '0;
    end
  end

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1;
  endfunction

  function automatic bin_update_t tally_address(input logic [ADDR_W-1:0] addr);
    bin_update_t r;
    bit          done;
    done    = 1'b0;
    r.kind  = KIND_FULL;
    r.index = '0;
    r.count = '0;
    if (base_model != '0) begin
      for (int i = 0; i < KNOWN_CALLERS; i++) begin
        if (!done && addr == base_model + CALLER_OFFSETS[i]) begin
          caller_tally[i] = bump(caller_tally[i]);
          r.kind  = KIND_KNOWN;
          r.index = BIN_W'(i);
          r.count = caller_tally[i];
          done    = 1'b1;
        end
      end
    end
    if (!done) begin
      other_tally = bump(other_tally);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!done && slot_addr[i] == addr) begin
          slot_tally[i] = bump(slot_tally[i]);
          r.kind  = KIND_EXIST;
          r.index = BIN_W'(i);
          r.count = slot_tally[i];
          done    = 1'b1;
        end else if (!done && slot_addr[i] == '0) begin
          slot_addr[i]  = addr;
          slot_tally[i] = 1;
          r.kind  = KIND_NEW;
          r.index = BIN_W'(i);
          r.count = 1;
          done    = 1'b1;
        end
      end
    end
    r.other = other_tally;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return base_model + CALLER_OFFSETS[$urandom_range(0, KNOWN_CALLERS - 1)];
    if (roll < 70) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 78) return '0;
    if (roll < 85) return ALL_ONES >> $urandom_range(0, 63);
    if (roll < 92) begin
      if (roll[0]) return base_model + CALLER_OFFSETS[$urandom_range(0, KNOWN_CALLERS - 1)] + 1;
      return base_model + CALLER_OFFSETS[$urandom_range(0, KNOWN_CALLERS - 1)] - 1;
    end
    return {$urandom, $urandom};
  endfunction

  // output check first, then predict from the accepted input word
  always @(posedge clk_i) begin
    bin_update_t due;
    result_taken = rst_ni && out_valid_o && !out_stall_i;
    if (result_taken) begin
      results_seen++;
      if (bin_updates_due.size() == 0) begin
        $error("unexpected result: hit_kind %0d bin_index %0d bin_count %0d other_count %0d",
               hit_kind_o, bin_index_o, bin_count_o, other_count_o);
        mismatches++;
      end else begin
        due = bin_updates_due.pop_front();
        if (hit_kind_o !== due.kind) begin
          $error("hit_kind: expected %0d, got %0d", due.kind, hit_kind_o);
          mismatches++;
        end
        if (bin_index_o !== due.index) begin
          $error("bin_index: expected %0d, got %0d", due.index, bin_index_o);
          mismatches++;
        end
        if (bin_count_o !== due.count) begin
          $error("bin_count: expected %0d, got %0d", due.count, bin_count_o);
          mismatches++;
        end
        if (other_count_o !== due.other) begin
          $error("other_count: expected %0d, got %0d", due.other, other_count_o);
          mismatches++;
        end
      end
    end
    word_taken = rst_ni && in_valid_i && !in_stall_o;
    if (word_taken) bin_updates_due.push_back(tally_address(return_address_i));
  end

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !word_taken) begin
      in_valid_i <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (addresses_to_send.size() > 0) begin
      return_address_i <= addresses_to_send.pop_front();
      in_valid_i       <= 1'b1;
      send_gap = lazy ? $urandom_range(0, 3) : 0;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver, with two long hold-offs to back the block up
  always @(negedge clk_i) begin
    if (results_seen >= next_hold && next_hold <= 1300) begin
      hold_left = 60;
      next_hold += 800;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (result_taken) stall_left = lazy ? $urandom_range(0, 3) : 0;
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (addresses_to_send.size() != 0 || bin_updates_due.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_base(input logic [ADDR_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    base_model = v;
  endtask

  initial begin
    for (int k = 0; k < POOL_SIZE; k++) addr_pool[k] = {$urandom, $urandom} | 64'h100;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: zero address hits the first empty slot without claiming it
    set_base('0);
    addresses_to_send.push_back('0);
    addresses_to_send.push_back('0);
    addresses_to_send.push_back(CALLER_OFFSETS[0]);
    addresses_to_send.push_back(ALL_ONES);
    addresses_to_send.push_back(64'h1);
    addresses_to_send.push_back('0);
    addresses_to_send.push_back(ALL_ONES);
    addresses_to_send.push_back(64'h8000_0000_0000_0000);
    wait_drained();

    // base at the top: caller addresses wrap around
    set_base(ALL_ONES);
    for (int i = 0; i < KNOWN_CALLERS; i++)
      addresses_to_send.push_back(base_model + CALLER_OFFSETS[i]);
    addresses_to_send.push_back(base_model + CALLER_OFFSETS[0]);
    addresses_to_send.push_back(ALL_ONES);
    wait_drained();

    set_base(64'h1);
    addresses_to_send.push_back(base_model + CALLER_OFFSETS[KNOWN_CALLERS - 1]);
    addresses_to_send.push_back(64'h1);
    addresses_to_send.push_back('0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: set_base('0);
        1: set_base({$urandom, $urandom});
        2: set_base(ALL_ONES);
        3: set_base(64'h1);
        4: set_base({$urandom, 32'h0});
        default: set_base({$urandom, $urandom});
      endcase
      lazy = (p != 3);
      for (int n = 0; n < 305; n++) addresses_to_send.push_back(pick_address());
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

endmodule
